// ===== hw/rtl/pulse_interval_bit_decoder_core_defines.svh =====
// ---------------------------------------------------------------------------
// pulse_interval_bit_decoder_core_defines.svh
// assertion macros used by the decoder core rtl, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef PULSE_INTERVAL_BIT_DECODER_CORE_DEFINES_SVH
`define PULSE_INTERVAL_BIT_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define PIBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pibd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PIBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pibd assertion failed");

`else

`define PIBD_ASSERT_NOW(lbl, ante, cons)
`define PIBD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/pibd_pkg.sv =====
// ---------------------------------------------------------------------------
// pibd_pkg
// shared types and constants of the pulse interval bit decoder
// ---------------------------------------------------------------------------
`default_nettype none

package pibd_pkg;

  // register map, index of each register (byte address is 4 * index)
  localparam int unsigned NUM_REGS    = 5;
  localparam int unsigned PADDR_W     = 5;
  localparam logic [2:0] REG_SHORT_THR = 3'd0;
  localparam logic [2:0] REG_LONG_THR  = 3'd1;
  localparam logic [2:0] REG_GAP_SKIP  = 3'd2;
  localparam logic [2:0] REG_RESTART   = 3'd3;
  localparam logic [2:0] REG_BLOCK_LEN = 3'd4;

  localparam logic [15:0] RESTART_RST   = 16'd1;
  localparam logic [15:0] BLOCK_LEN_RST = 16'd1;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // interval class
  typedef enum logic [1:0] {
    CLS_SHORT  = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_LONG   = 2'd2
  } cls_t;

  // block sequencer modes
  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_GAP      = 4'b0010,
    MODE_WRITING  = 4'b0100,
    MODE_STOPPING = 4'b1000
  } mode_t;

  // one classified beat in the queue
  typedef struct packed {
    logic begin_op;
    cls_t cls;
  } q_item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // configuration register contents
  typedef struct packed {
    logic [15:0] short_threshold;
    logic [15:0] long_threshold;
    logic [15:0] gap_skip_pulses;
    logic [15:0] restart_short_run;
    logic [15:0] block_length;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pibd_regs.sv =====
// ---------------------------------------------------------------------------
// pibd_regs
// apb configuration registers of the decoder
// ---------------------------------------------------------------------------
`default_nettype none

module pibd_regs
  import pibd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_threshold   <= '0;
      cfg_r.long_threshold    <= '0;
      cfg_r.gap_skip_pulses   <= '0;
      cfg_r.restart_short_run <= RESTART_RST;
      cfg_r.block_length      <= BLOCK_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHORT_THR: cfg_r.short_threshold   <= pwdata[15:0];
        REG_LONG_THR:  cfg_r.long_threshold    <= pwdata[15:0];
        REG_GAP_SKIP:  cfg_r.gap_skip_pulses   <= pwdata[15:0];
        REG_RESTART:   cfg_r.restart_short_run <= pwdata[15:0];
        REG_BLOCK_LEN: cfg_r.block_length      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_SHORT_THR: prdata = {16'd0, cfg_r.short_threshold};
      REG_LONG_THR:  prdata = {16'd0, cfg_r.long_threshold};
      REG_GAP_SKIP:  prdata = {16'd0, cfg_r.gap_skip_pulses};
      REG_RESTART:   prdata = {16'd0, cfg_r.restart_short_run};
      REG_BLOCK_LEN: prdata = {16'd0, cfg_r.block_length};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pibd_front.sv =====
// ---------------------------------------------------------------------------
// pibd_front
// accepts capture beats, forms the interval and sorts it into a class
// ---------------------------------------------------------------------------
`default_nettype none

module pibd_front
  import pibd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_capture_time,
  input  cfg_t        cfg,
  input  q_status_t   q_status,
  output logic        q_push,
  output q_item_t     q_item
);

  logic [15:0] last_capture_r;
  logic [15:0] interval;
  logic        accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // interval modulo 2^16
  assign interval = in_capture_time - last_capture_r;

  // classify, short tested first
  always_comb begin
    q_item.begin_op = in_op;
    if (interval < cfg.short_threshold) begin
      q_item.cls = CLS_SHORT;
    end else if (interval < cfg.long_threshold) begin
      q_item.cls = CLS_MEDIUM;
    end else begin
      q_item.cls = CLS_LONG;
    end
  end

  // previous capture, updated by every pulse beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_capture_r <= '0;
    end else if (accept && !in_op) begin
      last_capture_r <= in_capture_time;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pibd_queue.sv =====
// ---------------------------------------------------------------------------
// pibd_queue
// small fifo of classified beats between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module pibd_queue
  import pibd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_item_t   push_item,
  input  logic      pop,
  output q_item_t   head,
  output q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pibd_back.sv =====
// ---------------------------------------------------------------------------
// pibd_back
// block sequencer: gap, writing and stopping modes, bit packing, result beat
// ---------------------------------------------------------------------------
`default_nettype none

module pibd_back
  import pibd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  q_item_t     head,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_pos,
  output logic        out_block_end
);

  mode_t       mode_r, mode_nxt;
  logic        carrier_r, carrier_nxt;
  logic [15:0] pulse_cnt_r, pulse_cnt_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] byte_cnt_r, byte_cnt_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_index_r;
  logic        out_end_r;

  logic        adv;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_end;

  assign adv            = !out_valid_r || out_ready;
  assign pop            = !q_status.empty && adv;
  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_byte_r;
  assign out_byte_pos   = out_index_r;
  assign out_block_end  = out_end_r;

  // next state for the head beat
  always_comb begin
    logic [1:0]  n_bits;
    logic        b0, b1;
    logic [7:0]  sb1;
    logic [2:0]  bc1;
    logic        done1, end1;
    logic [15:0] bytes_inc;
    logic [15:0] pc_stop;

    mode_nxt      = mode_r;
    carrier_nxt   = carrier_r;
    pulse_cnt_nxt = pulse_cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    byte_cnt_nxt  = byte_cnt_r;
    emit          = 1'b0;
    emit_byte     = shift_r;
    emit_end      = 1'b0;
    n_bits        = 2'd0;
    b0            = 1'b0;
    b1            = 1'b0;
    sb1           = shift_r;
    bc1           = bit_cnt_r;
    done1         = 1'b0;
    end1          = 1'b0;
    bytes_inc     = byte_cnt_r + 16'd1;
    pc_stop       = '0;

    if (head.begin_op) begin
      mode_nxt      = MODE_GAP;
      pulse_cnt_nxt = '0;
      byte_cnt_nxt  = '0;
    end else begin
      unique case (mode_r)
        MODE_IDLE: ;
        MODE_GAP: begin
          if (pulse_cnt_r < cfg.gap_skip_pulses) begin
            pulse_cnt_nxt = pulse_cnt_r + 16'd1;
          end else if (head.cls != CLS_SHORT) begin
            carrier_nxt = 1'b0;
            bit_cnt_nxt = '0;
            mode_nxt    = MODE_WRITING;
          end
        end
        MODE_WRITING: begin
          // decode table: carrier and class give bits and new carrier
          if (carrier_r) begin
            case (head.cls)
              CLS_SHORT:  begin n_bits = 2'd1; b0 = 1'b0; carrier_nxt = 1'b1; end
              CLS_MEDIUM: begin n_bits = 2'd1; b0 = 1'b1; carrier_nxt = 1'b0; end
              default:    begin n_bits = 2'd0; carrier_nxt = 1'b1; end
            endcase
          end else begin
            if (head.cls == CLS_SHORT) begin
              n_bits      = 2'd1;
              b0          = 1'b1;
              carrier_nxt = 1'b0;
            end else begin
              n_bits      = 2'd2;
              b0          = 1'b0;
              b1          = (head.cls != CLS_MEDIUM);
              carrier_nxt = (head.cls == CLS_MEDIUM);
            end
          end
          // first bit
          if (n_bits != 2'd0) begin
            sb1   = {b0, shift_r[7:1]};
            bc1   = bit_cnt_r + 3'd1;
            done1 = (bc1 == 3'd0);
            end1  = done1 && (bytes_inc >= cfg.block_length);
            shift_nxt   = sb1;
            bit_cnt_nxt = bc1;
            if (done1) begin
              emit         = 1'b1;
              emit_byte    = sb1;
              emit_end     = end1;
              byte_cnt_nxt = bytes_inc;
              if (end1) begin
                mode_nxt      = MODE_STOPPING;
                pulse_cnt_nxt = '0;
              end
            end
          end
          // second bit, dropped once the block has ended
          if (n_bits == 2'd2 && !end1) begin
            shift_nxt   = {b1, sb1[7:1]};
            bit_cnt_nxt = bc1 + 3'd1;
            if (bc1 == 3'd7) begin
              emit         = 1'b1;
              emit_byte    = {b1, sb1[7:1]};
              emit_end     = (bytes_inc >= cfg.block_length);
              byte_cnt_nxt = bytes_inc;
              if (bytes_inc >= cfg.block_length) begin
                mode_nxt      = MODE_STOPPING;
                pulse_cnt_nxt = '0;
              end
            end
          end
        end
        MODE_STOPPING: begin
          // saturating run of short pulses
          if (head.cls == CLS_SHORT) begin
            pc_stop = (pulse_cnt_r == 16'hFFFF) ? pulse_cnt_r : pulse_cnt_r + 16'd1;
          end else begin
            pc_stop = '0;
          end
          if (pc_stop >= cfg.restart_short_run) begin
            mode_nxt      = MODE_GAP;
            pulse_cnt_nxt = '0;
            byte_cnt_nxt  = '0;
          end else begin
            pulse_cnt_nxt = pc_stop;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      carrier_r   <= 1'b0;
      pulse_cnt_r <= '0;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      byte_cnt_r  <= '0;
    end else if (pop) begin
      mode_r      <= mode_nxt;
      carrier_r   <= carrier_nxt;
      pulse_cnt_r <= pulse_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
    end
  end

  // result register, reloads whenever the previous beat is gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte_r  <= emit_byte;
      out_index_r <= byte_cnt_r;
      out_end_r   <= emit_end;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pulse_interval_bit_decoder_core.sv =====
// ---------------------------------------------------------------------------
// pulse_interval_bit_decoder_core
// decodes write pulse capture times into bytes of a block
//
//   channel   dir  handshake          payload
//   in_       in   in_valid/in_ready  in_op, in_capture_time
//   out_      out  out_valid/out_ready out_data_byte, out_byte_pos, out_block_end
//   config    in   apb psel/penable   paddr[4:0], pwdata, prdata
//
// one beat a cycle sustained while out_ready holds: the front classifies in its
// accept cycle, the back handles one queued beat a cycle and loads the result
// register, and out_valid comes from that register, loaded on a pop of the queue
// a stalled out_ready fills the queue (default two entries) before in_ready drops
// rst_n is synchronous; no clearing pass is needed after reset
// ---------------------------------------------------------------------------
`default_nettype none
`include "pulse_interval_bit_decoder_core_defines.svh"

module pulse_interval_bit_decoder_core
  import pibd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [15:0]        in_capture_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_data_byte,
  output logic [15:0]        out_byte_pos,
  output logic               out_block_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t      cfg;
  q_status_t q_status;
  q_item_t   q_in_item;
  q_item_t   q_head;
  logic      q_push;
  logic      q_pop;

  // configuration registers
  pibd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: interval and class
  pibd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_capture_time (in_capture_time),
    .cfg             (cfg),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_item          (q_in_item)
  );

  // queue between front and back
  pibd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // back: block sequencer and result register
  pibd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .head           (q_head),
    .q_status       (q_status),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_byte  (out_data_byte),
    .out_byte_pos   (out_byte_pos),
    .out_block_end  (out_block_end)
  );

  // checks
  `PIBD_ASSERT_NOW(a_queue_state, 1'b1, !(q_status.full && q_status.empty))
  `PIBD_ASSERT_NOW(a_pop_has_entry, q_pop, !q_status.empty)
  `PIBD_ASSERT_NEXT(a_result_from_pop, !out_valid, !out_valid || $past(q_pop))

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the pulse interval bit decoder: a queue-fed driver
// sends capture and begin beats, an in-bench decoder model predicts each byte
// and a monitor compares every result beat field by field
// ---------------------------------------------------------------------------

module tb_top
  import pibd_pkg::*;
();

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_BEGIN = 1'b1;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic        op;
    logic [15:0] stamp;
  } beat_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] index;
    logic        last;
  } byte_rec_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_PULSE;
  logic [15:0]        in_capture_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_data_byte;
  logic [15:0]        out_byte_pos;
  logic               out_block_end;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  pulse_interval_bit_decoder_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_capture_time (in_capture_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_byte_pos    (out_byte_pos),
    .out_block_end   (out_block_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // register shadow
  logic [15:0] thr_short   = '0;
  logic [15:0] thr_long    = '0;
  logic [15:0] gap_skip    = '0;
  logic [15:0] restart_run = RESTART_RST;
  logic [15:0] blk_len     = BLOCK_LEN_RST;

  // decoder model state
  mode_t       dec_mode     = MODE_IDLE;
  logic [15:0] prev_capture = '0;
  logic        carrier      = 1'b0;
  logic [15:0] pulse_cnt    = '0;
  logic [2:0]  bit_cnt      = '0;
  logic [7:0]  sh_byte      = '0;
  logic [15:0] byte_cnt     = '0;

  beat_t       capture_q[$];
  byte_rec_t   expected_bytes[$];
  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  logic [15:0] gen_time     = '0;
  bit          gaps_on      = 1'b1;
  bit          stalls_on    = 1'b1;
  int unsigned idle_left    = 0;
  int unsigned stall_left   = 0;
  beat_t       nxt_beat;
  byte_rec_t   want;

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------

  function automatic void open_block();
    dec_mode  = MODE_GAP;
    pulse_cnt = '0;
    byte_cnt  = '0;
  endfunction

  // shift one bit in, lsb first; reports a finished byte
  function automatic logic shift_in(input logic b, output byte_rec_t rec);
    rec     = '0;
    sh_byte = {b, sh_byte[7:1]};
    bit_cnt = bit_cnt + 3'd1;
    if (bit_cnt != 3'd0) return 1'b0;
    rec.data  = sh_byte;
    rec.index = byte_cnt;
    byte_cnt  = byte_cnt + 16'd1;
    if (byte_cnt >= blk_len) begin
      rec.last  = 1'b1;
      dec_mode  = MODE_STOPPING;
      pulse_cnt = '0;
    end
    return 1'b1;
  endfunction

  task automatic decode_capture(input logic op, input logic [15:0] stamp);
    logic [15:0] span;
    cls_t        c;
    logic        got;
    logic        second;
    byte_rec_t   rec;
    byte_rec_t   rec2;
    if (op == OP_BEGIN) begin
      open_block();
    end else begin
      span         = stamp - prev_capture;
      prev_capture = stamp;
      if (span < thr_short) c = CLS_SHORT;
      else if (span < thr_long) c = CLS_MEDIUM;
      else c = CLS_LONG;
      got = 1'b0;
      case (dec_mode)
        MODE_GAP: begin
          if (pulse_cnt < gap_skip) begin
            pulse_cnt = pulse_cnt + 16'd1;
          end else if (c != CLS_SHORT) begin
            carrier  = 1'b0;
            bit_cnt  = '0;
            dec_mode = MODE_WRITING;
          end
        end
        MODE_WRITING: begin
          if (carrier) begin
            if (c == CLS_SHORT) begin
              got = shift_in(1'b0, rec);
            end else if (c == CLS_MEDIUM) begin
              got     = shift_in(1'b1, rec);
              carrier = 1'b0;
            end
          end else if (c == CLS_SHORT) begin
            got = shift_in(1'b1, rec);
          end else begin
            // bit pair; the second bit is lost once the block has ended
            second = (c == CLS_LONG);
            got    = shift_in(1'b0, rec);
            if (dec_mode == MODE_WRITING) begin
              if (shift_in(second, rec2)) begin
                got = 1'b1;
                rec = rec2;
              end
            end
            carrier = (c == CLS_MEDIUM);
          end
        end
        MODE_STOPPING: begin
          if (c == CLS_SHORT) begin
            if (pulse_cnt != 16'hFFFF) pulse_cnt = pulse_cnt + 16'd1;
          end else begin
            pulse_cnt = '0;
          end
          if (pulse_cnt >= restart_run) open_block();
        end
        default: ;
      endcase
      if (got) expected_bytes.push_back(rec);
    end
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  function automatic int unsigned pick_idle(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 60);
  endfunction

  // interval landing in the wanted class under the current thresholds, random if none fits
  function automatic logic [15:0] pick_delta(input cls_t c);
    logic [15:0] lo;
    lo = (thr_long > thr_short) ? thr_long : thr_short;
    case (c)
      CLS_SHORT:
        pick_delta = (thr_short != 0) ? 16'($urandom_range(0, thr_short - 1)) : 16'($urandom);
      CLS_MEDIUM:
        pick_delta = (thr_long > thr_short) ?
                     16'($urandom_range(thr_short, thr_long - 1)) : 16'($urandom);
      default:
        pick_delta = 16'($urandom_range(lo, 16'hFFFF));
    endcase
  endfunction

  function automatic cls_t rand_class();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return CLS_SHORT;
    if (r < 75) return CLS_MEDIUM;
    return CLS_LONG;
  endfunction

  task automatic push_at(input logic [15:0] stamp);
    gen_time = stamp;
    capture_q.push_back('{OP_PULSE, stamp});
    beats_queued++;
  endtask

  task automatic push_pulse(input cls_t c);
    push_at(gen_time + pick_delta(c));
  endtask

  task automatic push_begin(input logic [15:0] stamp);
    capture_q.push_back('{OP_BEGIN, stamp});
    beats_queued++;
  endtask

  task automatic push_noise();
    if ($urandom_range(0, 7) == 0) push_begin(16'($urandom));
    else push_at(16'($urandom));
  endtask

  // mostly whole blocks with random content, the rest noise
  task automatic random_traffic(input int unsigned count);
    int unsigned stop_at;
    stop_at = beats_queued + count;
    while (beats_queued < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) != 0) push_begin(16'($urandom));
        repeat (gap_skip) push_pulse(rand_class());
        repeat ($urandom_range(0, 2)) push_pulse(CLS_SHORT);
        push_pulse($urandom_range(0, 1) ? CLS_MEDIUM : CLS_LONG);
        repeat (blk_len * 6 + $urandom_range(0, 6)) push_pulse(rand_class());
        repeat (restart_run + $urandom_range(0, 1)) push_pulse(CLS_SHORT);
      end else begin
        repeat ($urandom_range(1, 8)) push_noise();
      end
    end
  endtask

  // apb write: setup, access, then wait for pready
  task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SHORT_THR: thr_short   = val;
      REG_LONG_THR:  thr_long    = val;
      REG_GAP_SKIP:  gap_skip    = val;
      REG_RESTART:   restart_run = val;
      REG_BLOCK_LEN: blk_len     = val;
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [15:0] s, input logic [15:0] l, input logic [15:0] g,
                            input logic [15:0] r, input logic [15:0] b);
    reg_write(REG_SHORT_THR, s);
    reg_write(REG_LONG_THR, l);
    reg_write(REG_GAP_SKIP, g);
    reg_write(REG_RESTART, r);
    reg_write(REG_BLOCK_LEN, b);
  endtask

  // hold off until every beat is taken and every byte has come back
  task automatic drain();
    while (beats_taken != beats_queued || expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_capture(in_op, in_capture_time);
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (idle_left != 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (capture_q.size() != 0) begin
          nxt_beat        = capture_q.pop_front();
          in_valid        <= 1'b1;
          in_op           <= nxt_beat.op;
          in_capture_time <= nxt_beat.stamp;
          idle_left       = pick_idle(gaps_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor and back-pressure
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("result beat with nothing expected: data_byte %0h, byte_pos %0d",
                 out_data_byte, out_byte_pos);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_byte !== want.data) begin
            $error("data_byte: expected %0h, actual %0h", want.data, out_data_byte);
            mismatches++;
          end
          if (out_byte_pos !== want.index) begin
            $error("byte_pos: expected %0d, actual %0d", want.index, out_byte_pos);
            mismatches++;
          end
          if (out_block_end !== want.last) begin
            $error("block_end: expected %0b, actual %0b", want.last, out_block_end);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_idle(stalls_on);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [15:0] s_thr;
    logic [15:0] l_thr;
    logic [15:0] len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle pulses, gap skip, every carrier and class pair,
    // dropped second bit at block end, restart by short run
    load_setup(16'd100, 16'd300, 16'd2, 16'd3, 16'd2);
    push_at(16'hFFFF);
    push_at(16'h0000);
    push_begin(16'hFFFF);
    push_pulse(CLS_SHORT);
    push_pulse(CLS_SHORT);
    push_pulse(CLS_SHORT);
    push_pulse(CLS_MEDIUM);
    push_pulse(CLS_LONG);
    push_pulse(CLS_SHORT);
    push_pulse(CLS_MEDIUM);
    push_pulse(CLS_LONG);
    push_pulse(CLS_SHORT);
    push_pulse(CLS_MEDIUM);
    push_pulse(CLS_LONG);
    repeat (6) push_pulse(CLS_SHORT);
    push_pulse(CLS_MEDIUM);
    push_pulse(CLS_SHORT);
    push_pulse(CLS_MEDIUM);
    repeat (3) push_pulse(CLS_SHORT);
    push_begin(16'h0000);
    drain();

    // low extremes: every interval long, one-byte blocks
    load_setup(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001);
    push_begin(16'h5A5A);
    repeat (18) push_pulse(CLS_LONG);
    repeat (4) push_noise();
    drain();

    // high extremes: parked in gap mode
    load_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_begin(16'hA5A5);
    repeat (16) push_pulse(CLS_SHORT);
    repeat (4) push_noise();
    drain();

    // open-ended block, no restart by short run
    load_setup(16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_begin(16'h0000);
    repeat (80) push_pulse(rand_class());
    drain();

    // randomised settings, thresholds out of order now and then
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      s_thr = 16'($urandom_range(1, 3000));
      if (ph == 1 || $urandom_range(0, 5) == 0) l_thr = 16'($urandom_range(0, s_thr));
      else l_thr = s_thr + 16'($urandom_range(1, 5000));
      len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(5, 24)) : 16'($urandom_range(1, 4));
      load_setup(s_thr, l_thr, 16'($urandom_range(0, 6)), 16'($urandom_range(1, 5)), len);
      random_traffic(120);
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
